>>> hw/rtl/ctcgd_pkg.sv
// ============================================================================
// CTC greedy decoder package
// Shared widths, limits and result codes for the CTC greedy decoder.
// ============================================================================
package ctcgd_pkg;

  localparam int unsigned ProbW      = 16;
  localparam int unsigned IndexW     = 15;
  localparam int unsigned CountW     = 9;
  localparam int unsigned SumW       = 24;
  localparam int unsigned DictW      = 16;

  localparam int unsigned MaxClasses = 32768;
  localparam int unsigned MaxSteps   = 256;

  // The divider produces one quotient bit per cycle over the whole sum.
  localparam int unsigned DivSteps   = SumW;
  localparam int unsigned DivCntW    = $clog2(DivSteps + 1);
  localparam int unsigned RemW       = CountW + 1;

  localparam logic [IndexW-1:0] LastClassIdx = IndexW'(MaxClasses - 1);
  localparam logic [IndexW-1:0] BlankIdx     = '0;

  typedef enum logic {
    KIND_CHAR  = 1'b0,
    KIND_SCORE = 1'b1
  } kind_e;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> hw/rtl/ctcgd_div.sv
// ============================================================================
// CTC greedy decoder divider
// Restoring divider that computes one quotient bit per cycle.
// ============================================================================
module ctcgd_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [ctcgd_pkg::SumW-1:0]        dividend_i,
  input  logic [ctcgd_pkg::CountW-1:0]      divisor_i,
  output ctcgd_pkg::div_status_t            status_o,
  output logic [ctcgd_pkg::ProbW-1:0]       quotient_o
);

  logic [ctcgd_pkg::RemW-1:0]    rem_q, rem_d;
  logic [ctcgd_pkg::SumW-1:0]    quo_q, quo_d;
  logic [ctcgd_pkg::CountW-1:0]  div_q, div_d;
  logic [ctcgd_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;

  logic [ctcgd_pkg::RemW-1:0]    rem_shift;
  logic                          fits;

  always_comb begin
    rem_shift = {rem_q[ctcgd_pkg::RemW-2:0], quo_q[ctcgd_pkg::SumW-1]};
    fits      = rem_shift >= {1'b0, div_q};
    rem_d     = rem_q;
    quo_d     = quo_q;
    div_d     = div_q;
    cnt_d     = cnt_q;
    busy_d    = busy_q;
    done_d    = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? (rem_shift - {1'b0, div_q}) : rem_shift;
      quo_d = {quo_q[ctcgd_pkg::SumW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ctcgd_pkg::DivCntW'(ctcgd_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  // The mean of values below 2^16 never exceeds 16 bits; clamp all the same.
  assign quotient_o = (|quo_q[ctcgd_pkg::SumW-1:ctcgd_pkg::ProbW]) ?
                      '1 : quo_q[ctcgd_pkg::ProbW-1:0];
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

>>> hw/rtl/ctc_greedy_decoder_core.sv
// ============================================================================
// CTC greedy decoder core
// Streams class probabilities, picks each time step's arg-max class, collapses
// repeats and blanks, and reports characters and a mean score per sequence.
// ============================================================================
// Usage: probabilities enter on the in channel one item per cycle, class after
// class; last_class_i closes a time step and last_step_i (on that same item)
// closes the sequence. Class 0 is the blank; on a tie the lower index wins.
// Results leave on the out channel through a single output register. A step
// whose winner is a new non-blank class gives a character item in the cycle
// after the closing item is accepted. A sequence end also gives a score item
// carrying the truncated mean of the counted probabilities; the mean comes
// from a restoring divider that resolves one quotient bit per cycle. The
// score item is loaded once the divider is done (without it when no characters
// were counted) and the output register is free. The in channel takes one
// item per cycle except from a sequence end until its score item is loaded,
// and while the output register is full and not being drained. If the
// receiver stalls, input stops as soon as the output register is occupied.
// The dict_entries register is written over the cfg channel, which is always
// ready. Reset clears all running sums, the step state and the output valid,
// and sets dict_entries to 32768.
// ============================================================================
module ctc_greedy_decoder_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ctcgd_pkg::DictW-1:0]       cfg_dict_entries_i,
  // probability items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ctcgd_pkg::ProbW-1:0]       class_prob_i,
  input  logic                              last_class_i,
  input  logic                              last_step_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              kind_o,
  output logic [ctcgd_pkg::IndexW-1:0]      char_index_o,
  output logic [ctcgd_pkg::ProbW-1:0]       char_prob_o,
  output logic                              in_dict_o,
  output logic [ctcgd_pkg::ProbW-1:0]       avg_score_o,
  output logic [ctcgd_pkg::CountW-1:0]      char_count_o,
  output logic                              last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCORE
  } state_e;

  state_e                          state_q, state_d;
  logic [ctcgd_pkg::DictW-1:0]     dict_q, dict_d;
  logic [ctcgd_pkg::ProbW-1:0]     best_prob_q, best_prob_d;
  logic [ctcgd_pkg::IndexW-1:0]    best_idx_q, best_idx_d;
  logic [ctcgd_pkg::IndexW-1:0]    class_cnt_q, class_cnt_d;
  logic [ctcgd_pkg::IndexW-1:0]    prev_win_q, prev_win_d;
  logic [ctcgd_pkg::SumW-1:0]      sum_q, sum_d;
  logic [ctcgd_pkg::CountW-1:0]    seen_q, seen_d;
  logic [ctcgd_pkg::CountW-1:0]    final_cnt_q, final_cnt_d;
  logic [ctcgd_pkg::ProbW-1:0]     avg_q, avg_d;

  // Output register.
  logic                            ov_q, ov_d;
  logic                            okind_q, okind_d;
  logic [ctcgd_pkg::IndexW-1:0]    oidx_q, oidx_d;
  logic [ctcgd_pkg::ProbW-1:0]     oprob_q, oprob_d;
  logic                            odict_q, odict_d;
  logic [ctcgd_pkg::ProbW-1:0]     oavg_q, oavg_d;
  logic [ctcgd_pkg::CountW-1:0]    ocnt_q, ocnt_d;
  logic                            olast_q, olast_d;

  logic                            out_free;
  logic                            in_acc;
  logic                            take;
  logic [ctcgd_pkg::ProbW-1:0]     cur_prob;
  logic [ctcgd_pkg::IndexW-1:0]    cur_idx;
  logic                            emit_char;
  logic                            count_ok;
  logic [ctcgd_pkg::SumW-1:0]      sum_new;
  logic [ctcgd_pkg::CountW-1:0]    seen_new;

  logic                            div_start;
  ctcgd_pkg::div_status_t          div_status;
  logic [ctcgd_pkg::ProbW-1:0]     div_quotient;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !ov_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) && out_free;
  assign in_acc      = in_valid_i && in_ready_o;

  // Running arg-max including the current class; the first class always loads.
  always_comb begin
    take      = (class_cnt_q == ctcgd_pkg::BlankIdx) || (class_prob_i > best_prob_q);
    cur_prob  = take ? class_prob_i : best_prob_q;
    cur_idx   = take ? class_cnt_q : best_idx_q;
    emit_char = last_class_i && (cur_idx != ctcgd_pkg::BlankIdx) &&
                (cur_idx != prev_win_q);
    count_ok  = seen_q < ctcgd_pkg::CountW'(ctcgd_pkg::MaxSteps);
    sum_new   = (emit_char && count_ok) ?
                (sum_q + ctcgd_pkg::SumW'(cur_prob)) : sum_q;
    seen_new  = (emit_char && count_ok) ? (seen_q + 1'b1) : seen_q;
  end

  always_comb begin
    state_d     = state_q;
    dict_d      = cfg_valid_i ? cfg_dict_entries_i : dict_q;
    best_prob_d = best_prob_q;
    best_idx_d  = best_idx_q;
    class_cnt_d = class_cnt_q;
    prev_win_d  = prev_win_q;
    sum_d       = sum_q;
    seen_d      = seen_q;
    final_cnt_d = final_cnt_q;
    avg_d       = avg_q;
    div_start   = 1'b0;

    ov_d    = ov_q && !out_ready_i;
    okind_d = okind_q;
    oidx_d  = oidx_q;
    oprob_d = oprob_q;
    odict_d = odict_q;
    oavg_d  = oavg_q;
    ocnt_d  = ocnt_q;
    olast_d = olast_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!last_class_i) begin
            best_prob_d = cur_prob;
            best_idx_d  = cur_idx;
            if (class_cnt_q != ctcgd_pkg::LastClassIdx) begin
              class_cnt_d = class_cnt_q + 1'b1;
            end
          end else begin
            class_cnt_d = '0;
            best_prob_d = '0;
            best_idx_d  = '0;
            prev_win_d  = cur_idx;
            sum_d       = sum_new;
            seen_d      = seen_new;
            if (emit_char) begin
              ov_d    = 1'b1;
              okind_d = ctcgd_pkg::KIND_CHAR;
              oidx_d  = cur_idx;
              oprob_d = cur_prob;
              odict_d = ctcgd_pkg::DictW'(cur_idx) < dict_q;
              oavg_d  = '0;
              ocnt_d  = seen_new;
              olast_d = 1'b0;
            end
            if (last_step_i) begin
              // Sequence closes: hand the totals to the score path and restart.
              final_cnt_d = seen_new;
              sum_d       = '0;
              seen_d      = '0;
              prev_win_d  = ctcgd_pkg::BlankIdx;
              if (seen_new == '0) begin
                avg_d   = '0;
                state_d = ST_SCORE;
              end else begin
                div_start = 1'b1;
                state_d   = ST_DIV;
              end
            end
          end
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          avg_d   = div_quotient;
          state_d = ST_SCORE;
        end
      end
      ST_SCORE: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = ctcgd_pkg::KIND_SCORE;
          oidx_d  = '0;
          oprob_d = '0;
          odict_d = 1'b0;
          oavg_d  = avg_q;
          ocnt_d  = final_cnt_q;
          olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dict_q      <= ctcgd_pkg::DictW'(ctcgd_pkg::MaxClasses);
      best_prob_q <= '0;
      best_idx_q  <= '0;
      class_cnt_q <= '0;
      prev_win_q  <= '0;
      sum_q       <= '0;
      seen_q      <= '0;
      final_cnt_q <= '0;
      avg_q       <= '0;
      ov_q        <= 1'b0;
      okind_q     <= 1'b0;
      oidx_q      <= '0;
      oprob_q     <= '0;
      odict_q     <= 1'b0;
      oavg_q      <= '0;
      ocnt_q      <= '0;
      olast_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      dict_q      <= dict_d;
      best_prob_q <= best_prob_d;
      best_idx_q  <= best_idx_d;
      class_cnt_q <= class_cnt_d;
      prev_win_q  <= prev_win_d;
      sum_q       <= sum_d;
      seen_q      <= seen_d;
      final_cnt_q <= final_cnt_d;
      avg_q       <= avg_d;
      ov_q        <= ov_d;
      okind_q     <= okind_d;
      oidx_q      <= oidx_d;
      oprob_q     <= oprob_d;
      odict_q     <= odict_d;
      oavg_q      <= oavg_d;
      ocnt_q      <= ocnt_d;
      olast_q     <= olast_d;
    end
  end

  ctcgd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_new),
    .divisor_i  (seen_new),
    .status_o   (div_status),
    .quotient_o (div_quotient)
  );

  assign out_valid_o  = ov_q;
  assign kind_o       = okind_q;
  assign char_index_o = oidx_q;
  assign char_prob_o  = oprob_q;
  assign in_dict_o    = odict_q;
  assign avg_score_o  = oavg_q;
  assign char_count_o = ocnt_q;
  assign last_o       = olast_q;

endmodule

>>> tb/ctc_greedy_decoder_check.sv
// ============================================================================
// CTC greedy decoder checker
// Watches the configuration, probability and result channels, predicts the
// decoded results from the accepted probability items, and compares every
// accepted result against the oldest prediction, field by field.
// ============================================================================
module ctc_greedy_decoder_check (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [ctcgd_pkg::DictW-1:0]  cfg_dict_entries_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [ctcgd_pkg::ProbW-1:0]  class_prob_i,
  input  logic                         last_class_i,
  input  logic                         last_step_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         kind_i,
  input  logic [ctcgd_pkg::IndexW-1:0] char_index_i,
  input  logic [ctcgd_pkg::ProbW-1:0]  char_prob_i,
  input  logic                         in_dict_i,
  input  logic [ctcgd_pkg::ProbW-1:0]  avg_score_i,
  input  logic [ctcgd_pkg::CountW-1:0] char_count_i,
  input  logic                         last_i,
  output int unsigned                  mismatches_o,
  output int unsigned                  pending_o,
  output int unsigned                  results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ctcgd_pkg::kind_e                kind;
    logic [ctcgd_pkg::IndexW-1:0]    char_index;
    logic [ctcgd_pkg::ProbW-1:0]     char_prob;
    logic                            in_dict;
    logic [ctcgd_pkg::ProbW-1:0]     avg_score;
    logic [ctcgd_pkg::CountW-1:0]    char_count;
    logic                            last;
  } decoded_t;

  decoded_t decoded_fifo[$];

  logic [ctcgd_pkg::DictW-1:0]  dict_size;
  logic [ctcgd_pkg::ProbW-1:0]  step_best_prob;
  logic [ctcgd_pkg::IndexW-1:0] step_best_idx;
  logic [ctcgd_pkg::IndexW-1:0] class_idx;
  logic [ctcgd_pkg::IndexW-1:0] prev_winner;
  logic [ctcgd_pkg::SumW-1:0]   prob_sum;
  logic [ctcgd_pkg::CountW-1:0] chars_counted;
  int unsigned                  mismatch_cnt;
  int unsigned                  result_cnt;

  // Advances the decoder state by one probability item and queues whatever
  // results that item produces.
  task automatic greedy_decode_item(input logic [ctcgd_pkg::ProbW-1:0] prob,
                                    input logic step_end, input logic seq_end);
    decoded_t                     res;
    logic [ctcgd_pkg::IndexW-1:0] winner;
    logic [ctcgd_pkg::SumW-1:0]   quotient;
    if (class_idx == ctcgd_pkg::BlankIdx || prob > step_best_prob) begin
      step_best_prob = prob;
      step_best_idx  = class_idx;
    end
    if (!step_end) begin
      if (class_idx != ctcgd_pkg::LastClassIdx) class_idx++;
    end else begin
      class_idx = '0;
      winner    = step_best_idx;
      if (winner != ctcgd_pkg::BlankIdx && winner != prev_winner) begin
        // Past the character limit the character still goes out but is not counted.
        if (chars_counted < ctcgd_pkg::MaxSteps) begin
          chars_counted++;
          prob_sum = prob_sum + step_best_prob;
        end
        res.kind       = ctcgd_pkg::KIND_CHAR;
        res.char_index = winner;
        res.char_prob  = step_best_prob;
        res.in_dict    = (winner < dict_size);
        res.avg_score  = '0;
        res.char_count = chars_counted;
        res.last       = 1'b0;
        decoded_fifo   = {decoded_fifo, res};
      end
      prev_winner    = winner;
      step_best_prob = '0;
      step_best_idx  = '0;
      if (seq_end) begin
        quotient = (chars_counted == 0) ? '0 : prob_sum / chars_counted;
        if (quotient > 24'h00FFFF) quotient = 24'h00FFFF;
        res.kind       = ctcgd_pkg::KIND_SCORE;
        res.char_index = '0;
        res.char_prob  = '0;
        res.in_dict    = 1'b0;
        res.avg_score  = quotient[ctcgd_pkg::ProbW-1:0];
        res.char_count = chars_counted;
        res.last       = 1'b1;
        decoded_fifo   = {decoded_fifo, res};
        prob_sum      = '0;
        chars_counted = '0;
        prev_winner   = ctcgd_pkg::BlankIdx;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [ctcgd_pkg::SumW-1:0] want,
                             input logic [ctcgd_pkg::SumW-1:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic take_result();
    decoded_t want;
    result_cnt++;
    if (decoded_fifo.size() == 0) begin
      mismatch_cnt++;
      $display("%0t ns: result with nothing expected, actual kind %0h index %0h prob %0h",
               $time, kind_i, char_index_i, char_prob_i);
    end else begin
      want = decoded_fifo.pop_front();
      check_field("kind", want.kind, kind_i);
      check_field("char_index", want.char_index, char_index_i);
      check_field("char_prob", want.char_prob, char_prob_i);
      check_field("in_dict", want.in_dict, in_dict_i);
      check_field("avg_score", want.avg_score, avg_score_i);
      check_field("char_count", want.char_count, char_count_i);
      check_field("last", want.last, last_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dict_size      = ctcgd_pkg::DictW'(ctcgd_pkg::MaxClasses);
      step_best_prob = '0;
      step_best_idx  = '0;
      class_idx      = '0;
      prev_winner    = ctcgd_pkg::BlankIdx;
      prob_sum       = '0;
      chars_counted  = '0;
      mismatch_cnt   = 0;
      result_cnt     = 0;
      decoded_fifo.delete();
    end else begin
      if (out_valid_i && out_ready_i) take_result();
      if (cfg_valid_i && cfg_ready_i) dict_size = cfg_dict_entries_i;
      if (in_valid_i && in_ready_i) greedy_decode_item(class_prob_i, last_class_i, last_step_i);
    end
    mismatches_o <= mismatch_cnt;
    pending_o    <= decoded_fifo.size();
    results_o    <= result_cnt;
  end

endmodule

>>> tb/testbench.sv
// ============================================================================
// CTC greedy decoder testbench
// Streams directed and random probability items through the decoder core with
// random idling on both channels, across several dictionary sizes, while a
// separate checker predicts and compares every result item.
// ============================================================================
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let the divider finish after the last expected result, before a
  // register write and before the verdict.
  localparam int DrainCycles = 40;
  // Length of the one long receiver stall that backs the core up.
  localparam int LongHold    = 400;
  localparam int TextChars   = 270;
  localparam int ChunkItems  = 75;
  localparam int NumChunks   = 5;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [ctcgd_pkg::DictW-1:0]  cfg_dict;
  logic                         in_valid;
  logic                         in_ready;
  logic [ctcgd_pkg::ProbW-1:0]  class_prob;
  logic                         last_class;
  logic                         last_step;
  logic                         out_valid;
  logic                         out_ready;
  logic                         kind;
  logic [ctcgd_pkg::IndexW-1:0] char_index;
  logic [ctcgd_pkg::ProbW-1:0]  char_prob;
  logic                         in_dict;
  logic [ctcgd_pkg::ProbW-1:0]  avg_score;
  logic [ctcgd_pkg::CountW-1:0] char_count;
  logic                         last;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results;

  // calm switches off idling on both sides for the last part of the run.
  // hold_pending asks the receiver process for its one long stall.
  bit          calm;
  bit          hold_pending;
  int unsigned items_sent;
  int unsigned seqs_sent;
  int unsigned dict_writes;
  int unsigned chunk_start;
  logic [ctcgd_pkg::DictW-1:0] dict_plan [NumChunks];

  ctc_greedy_decoder_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_dict_entries_i (cfg_dict),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .class_prob_i       (class_prob),
    .last_class_i       (last_class),
    .last_step_i        (last_step),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .kind_o             (kind),
    .char_index_o       (char_index),
    .char_prob_o        (char_prob),
    .in_dict_o          (in_dict),
    .avg_score_o        (avg_score),
    .char_count_o       (char_count),
    .last_o             (last)
  );

  ctc_greedy_decoder_check u_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_dict_entries_i (cfg_dict),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .class_prob_i       (class_prob),
    .last_class_i       (last_class),
    .last_step_i        (last_step),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .kind_i             (kind),
    .char_index_i       (char_index),
    .char_prob_i        (char_prob),
    .in_dict_i          (in_dict),
    .avg_score_i        (avg_score),
    .char_count_i       (char_count),
    .last_i             (last),
    .mismatches_o       (mismatches),
    .pending_o          (pending),
    .results_o          (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the core hangs or a result never shows up.
  initial begin
    #12_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Offers one probability item and returns at the edge where it is taken.
  // Valid stays high across back-to-back items; it only drops for an idle
  // burst, which is decided before the item is put on the bus.
  task automatic push_prob(input logic [ctcgd_pkg::ProbW-1:0] prob, input logic step_end,
                           input logic seq_end);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    class_prob <= prob;
    last_class <= step_end;
    last_step  <= seq_end;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
  endtask

  // Writes the dictionary size once the core has drained. The score divider
  // can still be busy after a step that produced nothing, hence the pause.
  task automatic write_dict(input logic [ctcgd_pkg::DictW-1:0] value);
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_dict  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dict_writes++;
  endtask

  // Probabilities lean toward the extremes and small values so that ties
  // and blank winners come up often.
  function automatic logic [ctcgd_pkg::ProbW-1:0] pick_prob();
    logic [ctcgd_pkg::ProbW-1:0] prob;
    case ($urandom_range(0, 7))
      0:       prob = 16'h0000;
      1:       prob = 16'hFFFF;
      2:       prob = 16'h8000;
      3:       prob = 16'($urandom_range(0, 15));
      default: prob = 16'($urandom);
    endcase
    return prob;
  endfunction

  // One time step of random classes. A stray sequence-end flag on a class
  // that does not close the step must be ignored by the core.
  task automatic send_step(input int n_classes, input bit seq_end);
    for (int c = 0; c < n_classes; c++) begin
      if (c == n_classes - 1) push_prob(pick_prob(), 1'b1, seq_end);
      else push_prob(pick_prob(), 1'b0, $urandom_range(0, 7) == 0);
    end
  endtask

  // A well-formed sequence: mostly narrow steps so that winners repeat and
  // collapse, now and then a wider one.
  task automatic send_random_seq();
    int n_steps;
    int n_classes;
    n_steps = $urandom_range(1, 10);
    for (int s = 0; s < n_steps; s++) begin
      n_classes = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      send_step(n_classes, s == n_steps - 1);
    end
    seqs_sent++;
  endtask

  // Directed cases, run with a dictionary of two entries so that class 1 is
  // text and class 2 is not.
  task automatic run_directed();
    // A lone blank step ending the sequence: no characters, mean of zero.
    push_prob(16'h1234, 1'b1, 1'b1);
    // Tie between blank and class 1: the lower index wins, so nothing is
    // emitted. The stray sequence-end flag on the second class is ignored.
    push_prob(16'd100, 1'b0, 1'b0);
    push_prob(16'd100, 1'b0, 1'b1);
    push_prob(16'd50, 1'b1, 1'b0);
    // Class 1 wins at full scale; the later equal value does not displace it.
    push_prob(16'd10, 1'b0, 1'b0);
    push_prob(16'hFFFF, 1'b0, 1'b0);
    push_prob(16'hFFFF, 1'b0, 1'b0);
    push_prob(16'd5, 1'b1, 1'b0);
    // Class 1 again right away collapses into the previous character.
    push_prob(16'h0000, 1'b0, 1'b0);
    push_prob(16'd7, 1'b1, 1'b0);
    // A blank step in between lets the same class be emitted again.
    push_prob(16'hFFFF, 1'b0, 1'b0);
    push_prob(16'hFFFF, 1'b1, 1'b0);
    push_prob(16'h0000, 1'b0, 1'b0);
    push_prob(16'h0001, 1'b1, 1'b0);
    // Class 2 lies outside the dictionary; the sequence closes on it.
    push_prob(16'h0000, 1'b0, 1'b0);
    push_prob(16'h0000, 1'b0, 1'b0);
    push_prob(16'h8000, 1'b1, 1'b1);
    seqs_sent += 2;
  endtask

  // A sequence with more characters than the count limit. Winners alternate
  // between classes 1 and 2 so that none collapse. The counted ones are all
  // full scale, which drives the sum to its peak and the mean to full scale.
  task automatic send_long_text();
    for (int k = 0; k < TextChars; k++) begin
      push_prob(16'h0000, 1'b0, 1'b0);
      if (k % 2 == 1) push_prob(16'h0000, 1'b0, 1'b0);
      push_prob(k < 256 ? 16'hFFFF : 16'($urandom_range(1, 16'hFFFF)), 1'b1,
                k == TextChars - 1);
    end
    seqs_sent++;
  endtask

  // Receiver: random stalls, one long hold-off on request, and no stalls at
  // all once the run is calm.
  initial begin
    out_ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    rst_ni       = 1'b0;
    cfg_valid    = 1'b0;
    cfg_dict     = '0;
    in_valid     = 1'b0;
    class_prob   = '0;
    last_class   = 1'b0;
    last_step    = 1'b0;
    calm         = 1'b0;
    hold_pending = 1'b0;
    items_sent   = 0;
    seqs_sent    = 0;
    dict_writes  = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_dict(16'd2);
    run_directed();

    // An empty dictionary: every character is out of it.
    write_dict(16'd0);
    send_long_text();

    // Random sequences under a mix of dictionary sizes, including the full
    // one. The second chunk carries the long receiver stall; the last one
    // runs with no idling on either side.
    dict_plan[0] = 16'($urandom_range(1, 8));
    dict_plan[1] = 16'd32768;
    dict_plan[2] = 16'($urandom_range(0, 32768));
    dict_plan[3] = 16'd1;
    dict_plan[4] = 16'($urandom_range(2, 6));
    for (int ch = 0; ch < NumChunks; ch++) begin
      write_dict(dict_plan[ch]);
      if (ch == 1) hold_pending = 1'b1;
      if (ch == NumChunks - 1) calm = 1'b1;
      chunk_start = items_sent;
      while (items_sent - chunk_start < ChunkItems) send_random_seq();
    end

    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d probability items in %0d sequences, %0d dictionary writes,",
             items_sent, seqs_sent, dict_writes);
    $display("and %0d result items: ties, blanks, collapse and character count saturation.",
             results);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
